/* hw/rtl/xpel_pkg.sv */
// ----------------------------------------------------------------------------
// XPath lexer package
// Token kind codes, character codes, lexer modes and the character class and
// keyword functions shared by the lexer core and the top level.
// ----------------------------------------------------------------------------
package xpel_pkg;

  localparam int TOK_W      = 13;
  localparam int KIND_W     = 6;
  localparam int RES_MAX    = 4;
  localparam int SLOT_COUNT = 8;
  localparam int FIFO_DEPTH = 8;
  localparam int KW_MAX     = 9;
  localparam int KW_COUNT   = 21;

  localparam logic [KIND_W-1:0] K_END     = 6'd0;
  localparam logic [KIND_W-1:0] K_BAD     = 6'd1;
  localparam logic [KIND_W-1:0] K_NUM     = 6'd2;
  localparam logic [KIND_W-1:0] K_STR     = 6'd3;
  localparam logic [KIND_W-1:0] K_NAME    = 6'd4;
  localparam logic [KIND_W-1:0] K_WILD    = 6'd5;
  localparam logic [KIND_W-1:0] K_MUL     = 6'd6;
  localparam logic [KIND_W-1:0] K_SL      = 6'd7;
  localparam logic [KIND_W-1:0] K_SLSL    = 6'd8;
  localparam logic [KIND_W-1:0] K_DOT1    = 6'd9;
  localparam logic [KIND_W-1:0] K_DOT2    = 6'd10;
  localparam logic [KIND_W-1:0] K_AXIS    = 6'd11;
  localparam logic [KIND_W-1:0] K_COL     = 6'd12;
  localparam logic [KIND_W-1:0] K_ASG     = 6'd13;
  localparam logic [KIND_W-1:0] K_LBRK    = 6'd14;
  localparam logic [KIND_W-1:0] K_RBRK    = 6'd15;
  localparam logic [KIND_W-1:0] K_LPAR    = 6'd16;
  localparam logic [KIND_W-1:0] K_RPAR    = 6'd17;
  localparam logic [KIND_W-1:0] K_ATS     = 6'd18;
  localparam logic [KIND_W-1:0] K_COM     = 6'd19;
  localparam logic [KIND_W-1:0] K_BAR     = 6'd20;
  localparam logic [KIND_W-1:0] K_EQS     = 6'd21;
  localparam logic [KIND_W-1:0] K_NEQ     = 6'd22;
  localparam logic [KIND_W-1:0] K_LTH     = 6'd23;
  localparam logic [KIND_W-1:0] K_LEQ     = 6'd24;
  localparam logic [KIND_W-1:0] K_GTH     = 6'd25;
  localparam logic [KIND_W-1:0] K_GEQ     = 6'd26;
  localparam logic [KIND_W-1:0] K_ADD     = 6'd27;
  localparam logic [KIND_W-1:0] K_SUB     = 6'd28;
  localparam logic [KIND_W-1:0] K_VAR     = 6'd29;
  localparam logic [KIND_W-1:0] K_KW_BASE = 6'd30;
  localparam logic [KIND_W-1:0] K_NONE    = 6'd63;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_BANG  = "!";
  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_LBRK  = "[";
  localparam logic [7:0] CH_RBRK  = "]";
  localparam logic [7:0] CH_LPAR  = "(";
  localparam logic [7:0] CH_RPAR  = ")";
  localparam logic [7:0] CH_AT    = "@";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_BAR   = "|";
  localparam logic [7:0] CH_DOLL  = "$";
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UND   = "_";

  localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
    "and", "or", "not", "div", "mod", "eq", "ne", "lt", "le", "gt", "ge",
    "if", "then", "else", "for", "let", "in", "return", "some", "every",
    "satisfies"};
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd2, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
    4'd2, 4'd4, 4'd4, 4'd3, 4'd3, 4'd2, 4'd6, 4'd4, 4'd5, 4'd9};

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_OP   = 5'b00010,
    M_NAME = 5'b00100,
    M_NUM  = 5'b01000,
    M_STR  = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TOK_W-1:0]  start;
    logic [TOK_W-1:0]  len;
    logic              eoe;
  } tok_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic name_first(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UND;
  endfunction

  function automatic logic name_more(input logic [7:0] b);
    return name_first(b) || is_dig(b) || b == CH_MINUS || b == CH_DOT;
  endfunction

  function automatic logic operand_lead(input logic [7:0] b);
    return is_dig(b) || b == CH_DOT || b == CH_SLASH || name_first(b) || b == CH_AT ||
           b == CH_DOLL || b == CH_LPAR || b == CH_SQ || b == CH_DQ;
  endfunction

  function automatic logic is_op_lead(input logic [7:0] b);
    return b == CH_SLASH || b == CH_DOT || b == CH_COLON || b == CH_BANG ||
           b == CH_LT || b == CH_GT;
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] b);
    logic [KIND_W-1:0] k;
    k = K_BAD;
    if (b == CH_SLASH) k = K_SL;
    else if (b == CH_DOT) k = K_DOT1;
    else if (b == CH_COLON) k = K_COL;
    else if (b == CH_LBRK) k = K_LBRK;
    else if (b == CH_RBRK) k = K_RBRK;
    else if (b == CH_LPAR) k = K_LPAR;
    else if (b == CH_RPAR) k = K_RPAR;
    else if (b == CH_AT) k = K_ATS;
    else if (b == CH_COMMA) k = K_COM;
    else if (b == CH_BAR) k = K_BAR;
    else if (b == CH_EQ) k = K_EQS;
    else if (b == CH_LT) k = K_LTH;
    else if (b == CH_GT) k = K_GTH;
    else if (b == CH_PLUS) k = K_ADD;
    else if (b == CH_MINUS) k = K_SUB;
    else if (b == CH_DOLL) k = K_VAR;
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [KIND_W-1:0] k;
    k = K_NONE;
    if (a == CH_SLASH && b == CH_SLASH) k = K_SLSL;
    else if (a == CH_DOT && b == CH_DOT) k = K_DOT2;
    else if (a == CH_COLON && b == CH_COLON) k = K_AXIS;
    else if (a == CH_BANG && b == CH_EQ) k = K_NEQ;
    else if (a == CH_LT && b == CH_EQ) k = K_LEQ;
    else if (a == CH_GT && b == CH_EQ) k = K_GEQ;
    else if (a == CH_COLON && b == CH_EQ) k = K_ASG;
    return k;
  endfunction

  // The name is held right-aligned with zero bytes above it.
  function automatic logic [KIND_W-1:0] kw_kind(input logic [8*KW_MAX-1:0] chars,
                                               input logic [3:0] fill);
    logic [KIND_W-1:0] k;
    logic              hit;
    k   = K_NAME;
    hit = 1'b0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (!hit && fill == KW_LEN[i] && chars == KW_TEXT[i]) begin
        hit = 1'b1;
        k   = K_KW_BASE + KIND_W'(i);
      end
    end
    return k;
  endfunction

endpackage

/* hw/rtl/xpath_expression_lexer.sv */
// ----------------------------------------------------------------------------
// XPath expression lexer
// Tokens enter the queue on an accepted byte beat and leave from its head.
// Throughput: one byte per cycle unless stalled; a byte yields up to four
// token beats, leaving through an eight-entry queue one per unstalled cycle.
// Input is stalled while more than four tokens wait in that queue.
// Reset is synchronous and active low; it empties the queue and clears state.
// ----------------------------------------------------------------------------
module xpath_expression_lexer import xpel_pkg::*; #(
  parameter int MAX_EXPR_BYTES = 4096,
  parameter int MAX_NESTING    = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte_in,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_token_kind,
  output logic [TOK_W-1:0]  out_token_start,
  output logic [TOK_W-1:0]  out_token_length,
  output logic              out_end_of_expression
);

  tok_t       toks [RES_MAX];
  tok_t       head;
  logic [2:0] tok_count;
  logic       acc, full;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  xpel_core #(
    .MAX_EXPR_BYTES (MAX_EXPR_BYTES),
    .MAX_NESTING    (MAX_NESTING)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .byte_in   (in_byte_in),
    .last_byte (in_last_byte),
    .tok       (toks),
    .tok_count (tok_count)
  );

  xpel_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (acc),
    .wr_tok    (toks),
    .wr_count  (tok_count),
    .rd        (out_valid && !out_stall),
    .rd_tok    (head),
    .full      (full),
    .not_empty (out_valid)
  );

  assign out_token_kind        = head.kind;
  assign out_token_start       = head.start;
  assign out_token_length      = head.len;
  assign out_end_of_expression = head.eoe;

  a_fin_gives_token: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last_byte |=> out_valid)
    else $error("final beat produced no token");
  a_eoe_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_end_of_expression == (out_token_kind == K_END))
    else $error("end flag disagrees with token kind");
  a_eoe_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_expression |-> out_token_length == '0)
    else $error("end token with nonzero length");

endmodule

/* hw/rtl/xpel_core.sv */
// ----------------------------------------------------------------------------
// XPath lexer core
// Holds the lexer state and combinationally turns one accepted byte into
// up to four tokens.
// ----------------------------------------------------------------------------
module xpel_core import xpel_pkg::*; #(
  parameter int MAX_EXPR_BYTES = 4096,
  parameter int MAX_NESTING    = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] byte_in,
  input  logic       last_byte,
  output tok_t       tok [RES_MAX],
  output logic [2:0] tok_count
);

  localparam int PW = $clog2(MAX_EXPR_BYTES + 1);
  localparam int NW = $clog2(MAX_NESTING + 1);
  localparam logic [PW-1:0] MAXP = PW'(MAX_EXPR_BYTES);
  localparam logic [NW-1:0] MAXN = NW'(MAX_NESTING);

  logic [PW-1:0]         pos_r, pos_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [PW-1:0]         pstart_r, pstart_nxt;
  logic [7:0]            pfirst_r, pfirst_nxt;
  logic [7:0]            quote_r, quote_nxt;
  logic                  dot_r, dot_nxt;
  logic                  esc_r, esc_nxt;
  logic [8*KW_MAX-1:0]   chars_r, chars_nxt;
  logic [3:0]            fill_r, fill_nxt;
  logic [NW-1:0]         brk_r, brk_nxt;
  logic [NW-1:0]         par_r, par_nxt;
  logic [KIND_W-1:0]     prev_r, prev_nxt;
  logic                  star_r, star_nxt;
  logic [PW-1:0]         star_start_r, star_start_nxt;
  logic                  sign_r, sign_nxt;
  logic                  minus_r, minus_nxt;
  logic [PW-1:0]         sign_start_r, sign_start_nxt;

  logic [KIND_W-1:0]     s_kind  [SLOT_COUNT];
  logic [PW-1:0]         s_start [SLOT_COUNT];
  logic [PW-1:0]         s_len   [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] s_v;

  logic [PW-1:0]         at, fin_pos, star_end, sign_end;
  logic                  go, beg, blank, open, left;

  always_comb begin
    pos_nxt        = pos_r;
    mode_nxt       = mode_r;
    pstart_nxt     = pstart_r;
    pfirst_nxt     = pfirst_r;
    quote_nxt      = quote_r;
    dot_nxt        = dot_r;
    esc_nxt        = esc_r;
    chars_nxt      = chars_r;
    fill_nxt       = fill_r;
    brk_nxt        = brk_r;
    par_nxt        = par_r;
    prev_nxt       = prev_r;
    star_nxt       = star_r;
    star_start_nxt = star_start_r;
    sign_nxt       = sign_r;
    minus_nxt      = minus_r;
    sign_start_nxt = sign_start_r;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      s_kind[i]  = K_END;
      s_start[i] = '0;
      s_len[i]   = '0;
    end
    s_v      = '0;
    at       = pos_r;
    go       = 1'b1;
    beg      = 1'b0;
    blank    = is_blank(byte_in);
    open     = (brk_r != '0) || (par_r != '0);
    left     = prev_r == K_NAME || prev_r == K_RPAR || prev_r == K_RBRK ||
               ((prev_r == K_NUM || prev_r == K_STR) && open);
    star_end = (star_start_r < MAXP) ? star_start_r + 1'b1 : MAXP;
    sign_end = (sign_start_r < MAXP) ? sign_start_r + 1'b1 : MAXP;

    if (star_r) begin
      if (blank) begin
        go = 1'b0;
      end else if (sign_r) begin
        s_v[0] = 1'b1;
        s_kind[0] = (left && operand_lead(byte_in)) ? K_MUL : K_WILD;
        s_start[0] = star_start_r;
        s_len[0] = star_end - star_start_r;
        s_v[1] = 1'b1;
        s_kind[1] = minus_r ? K_SUB : K_ADD;
        s_start[1] = sign_start_r;
        s_len[1] = sign_end - sign_start_r;
        prev_nxt = s_kind[1];
        star_nxt = 1'b0;
        sign_nxt = 1'b0;
      end else if (byte_in == CH_PLUS || byte_in == CH_MINUS) begin
        sign_nxt = 1'b1;
        minus_nxt = byte_in == CH_MINUS;
        sign_start_nxt = at;
        go = 1'b0;
      end else begin
        s_v[0] = 1'b1;
        s_kind[0] = (left && operand_lead(byte_in)) ? K_MUL : K_WILD;
        s_start[0] = star_start_r;
        s_len[0] = star_end - star_start_r;
        prev_nxt = s_kind[0];
        star_nxt = 1'b0;
      end
    end

    if (go) begin
      unique case (mode_r)
        M_NAME: begin
          if (name_more(byte_in)) begin
            if (fill_r < 4'(KW_MAX)) chars_nxt = {chars_r[8*KW_MAX-9:0], byte_in};
            if (fill_r <= 4'(KW_MAX)) fill_nxt = fill_r + 1'b1;
          end else begin
            s_v[2] = 1'b1;
            s_kind[2] = kw_kind(chars_r, fill_r);
            s_start[2] = pstart_r;
            s_len[2] = at - pstart_r;
            prev_nxt = s_kind[2];
            mode_nxt = M_IDLE;
            beg = 1'b1;
          end
        end
        M_NUM: begin
          if (is_dig(byte_in)) begin
            mode_nxt = M_NUM;
          end else if (byte_in == CH_DOT && !dot_r) begin
            dot_nxt = 1'b1;
          end else begin
            s_v[2] = 1'b1;
            s_kind[2] = K_NUM;
            s_start[2] = pstart_r;
            s_len[2] = at - pstart_r;
            prev_nxt = K_NUM;
            mode_nxt = M_IDLE;
            beg = 1'b1;
          end
        end
        M_STR: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (byte_in == CH_BSL) begin
            esc_nxt = 1'b1;
          end else if (byte_in == quote_r) begin
            s_v[2] = 1'b1;
            s_kind[2] = K_STR;
            s_start[2] = pstart_r;
            s_len[2] = ((at < MAXP) ? at + 1'b1 : MAXP) - pstart_r;
            prev_nxt = K_STR;
            mode_nxt = M_IDLE;
          end
        end
        M_OP: begin
          mode_nxt = M_IDLE;
          if (pair_kind(pfirst_r, byte_in) != K_NONE) begin
            s_v[2] = 1'b1;
            s_kind[2] = pair_kind(pfirst_r, byte_in);
            s_start[2] = pstart_r;
            s_len[2] = ((at < MAXP) ? at + 1'b1 : MAXP) - pstart_r;
            prev_nxt = s_kind[2];
          end else if (pfirst_r == CH_DOT && is_dig(byte_in)) begin
            mode_nxt = M_NUM;
            dot_nxt = 1'b1;
          end else begin
            s_v[2] = 1'b1;
            s_kind[2] = single_kind(pfirst_r);
            s_start[2] = pstart_r;
            s_len[2] = at - pstart_r;
            prev_nxt = s_kind[2];
            beg = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
          beg = 1'b1;
        end
      endcase
    end

    if (beg && !blank) begin
      priority if (byte_in == CH_STAR) begin
        star_nxt = 1'b1;
        star_start_nxt = at;
      end else if (is_op_lead(byte_in)) begin
        mode_nxt = M_OP;
        pfirst_nxt = byte_in;
        pstart_nxt = at;
      end else if (single_kind(byte_in) != K_BAD) begin
        s_v[3] = 1'b1;
        s_kind[3] = single_kind(byte_in);
        s_start[3] = at;
        s_len[3] = ((at < MAXP) ? at + 1'b1 : MAXP) - at;
        prev_nxt = s_kind[3];
        if (s_kind[3] == K_LBRK && brk_r < MAXN) brk_nxt = brk_r + 1'b1;
        if (s_kind[3] == K_RBRK && brk_r != '0) brk_nxt = brk_r - 1'b1;
        if (s_kind[3] == K_LPAR && par_r < MAXN) par_nxt = par_r + 1'b1;
        if (s_kind[3] == K_RPAR && par_r != '0) par_nxt = par_r - 1'b1;
      end else if (byte_in == CH_SQ || byte_in == CH_DQ) begin
        mode_nxt = M_STR;
        quote_nxt = byte_in;
        esc_nxt = 1'b0;
        pstart_nxt = at;
      end else if (is_dig(byte_in)) begin
        mode_nxt = M_NUM;
        dot_nxt = 1'b0;
        pstart_nxt = at;
      end else if (name_first(byte_in)) begin
        mode_nxt = M_NAME;
        pstart_nxt = at;
        chars_nxt = {{(8*KW_MAX-8){1'b0}}, byte_in};
        fill_nxt = 4'd1;
      end else begin
        s_v[3] = 1'b1;
        s_kind[3] = K_BAD;
        s_start[3] = at;
        s_len[3] = ((at < MAXP) ? at + 1'b1 : MAXP) - at;
        prev_nxt = K_BAD;
      end
    end

    pos_nxt = (at < MAXP) ? at + 1'b1 : MAXP;
    fin_pos = pos_nxt;

    if (last_byte) begin
      if (star_nxt) begin
        s_v[4] = 1'b1;
        s_kind[4] = K_WILD;
        s_start[4] = star_start_nxt;
        s_len[4] = ((star_start_nxt < MAXP) ? star_start_nxt + 1'b1 : MAXP) - star_start_nxt;
        if (sign_nxt) begin
          s_v[5] = 1'b1;
          s_kind[5] = minus_nxt ? K_SUB : K_ADD;
          s_start[5] = sign_start_nxt;
          s_len[5] = ((sign_start_nxt < MAXP) ? sign_start_nxt + 1'b1 : MAXP)
                     - sign_start_nxt;
        end
      end
      unique case (mode_nxt)
        M_NAME: begin
          s_v[6] = 1'b1;
          s_kind[6] = kw_kind(chars_nxt, fill_nxt);
        end
        M_NUM: begin
          s_v[6] = 1'b1;
          s_kind[6] = K_NUM;
        end
        M_STR: begin
          s_v[6] = 1'b1;
          s_kind[6] = K_STR;
        end
        M_OP: begin
          s_v[6] = 1'b1;
          s_kind[6] = single_kind(pfirst_nxt);
        end
        default: begin
          s_v[6] = 1'b0;
        end
      endcase
      s_start[6] = pstart_nxt;
      s_len[6] = fin_pos - pstart_nxt;
      s_v[7] = 1'b1;
      s_kind[7] = K_END;
      s_start[7] = fin_pos;
      s_len[7] = '0;

      pos_nxt        = '0;
      mode_nxt       = M_IDLE;
      pstart_nxt     = '0;
      pfirst_nxt     = '0;
      quote_nxt      = '0;
      dot_nxt        = 1'b0;
      esc_nxt        = 1'b0;
      chars_nxt      = '0;
      fill_nxt       = '0;
      brk_nxt        = '0;
      par_nxt        = '0;
      prev_nxt       = K_NONE;
      star_nxt       = 1'b0;
      star_start_nxt = '0;
      sign_nxt       = 1'b0;
      minus_nxt      = 1'b0;
      sign_start_nxt = '0;
    end
  end

  // Tokens beyond the fourth of one byte are dropped.
  always_comb begin
    tok_count = '0;
    for (int i = 0; i < RES_MAX; i++) begin
      tok[i] = '0;
    end
    for (int j = 0; j < SLOT_COUNT; j++) begin
      if (s_v[j] && tok_count < 3'(RES_MAX)) begin
        tok[tok_count[1:0]].kind  = s_kind[j];
        tok[tok_count[1:0]].start = TOK_W'(s_start[j]);
        tok[tok_count[1:0]].len   = TOK_W'(s_len[j]);
        tok[tok_count[1:0]].eoe   = s_kind[j] == K_END;
        tok_count = tok_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      mode_r       <= M_IDLE;
      pstart_r     <= '0;
      pfirst_r     <= '0;
      quote_r      <= '0;
      dot_r        <= 1'b0;
      esc_r        <= 1'b0;
      chars_r      <= '0;
      fill_r       <= '0;
      brk_r        <= '0;
      par_r        <= '0;
      prev_r       <= K_NONE;
      star_r       <= 1'b0;
      star_start_r <= '0;
      sign_r       <= 1'b0;
      minus_r      <= 1'b0;
      sign_start_r <= '0;
    end else if (acc) begin
      pos_r        <= pos_nxt;
      mode_r       <= mode_nxt;
      pstart_r     <= pstart_nxt;
      pfirst_r     <= pfirst_nxt;
      quote_r      <= quote_nxt;
      dot_r        <= dot_nxt;
      esc_r        <= esc_nxt;
      chars_r      <= chars_nxt;
      fill_r       <= fill_nxt;
      brk_r        <= brk_nxt;
      par_r        <= par_nxt;
      prev_r       <= prev_nxt;
      star_r       <= star_nxt;
      star_start_r <= star_start_nxt;
      sign_r       <= sign_nxt;
      minus_r      <= minus_nxt;
      sign_start_r <= sign_start_nxt;
    end
  end

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last_byte |=> pos_r == '0 && mode_r == M_IDLE && !star_r)
    else $error("state not cleared after the final beat");
  a_star_idle: assert property (@(posedge clk) disable iff (!rst_n)
    star_r |-> mode_r == M_IDLE)
    else $error("star held while a token is open");
  a_sign_star: assert property (@(posedge clk) disable iff (!rst_n)
    sign_r |-> star_r)
    else $error("sign held without a held star");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAXP && pstart_r <= pos_r)
    else $error("position out of range");

endmodule

/* hw/rtl/xpression_lexer_placeholder_removed.sv */
// ----------------------------------------------------------------------------
// XPath lexer token queue
// Small queue taking up to four tokens per write beat, giving one per read beat.
// ----------------------------------------------------------------------------
module xpel_queue import xpel_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr,
  input  tok_t       wr_tok [RES_MAX],
  input  logic [2:0] wr_count,
  input  logic       rd,
  output tok_t       rd_tok,
  output logic       full,
  output logic       not_empty
);

  localparam int AW = $clog2(FIFO_DEPTH);

  tok_t            mem_r [FIFO_DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic [2:0]      n_in;

  assign n_in      = wr ? wr_count : 3'd0;
  assign full      = cnt_r > (AW+1)'(FIFO_DEPTH - RES_MAX);
  assign not_empty = cnt_r != '0;
  assign rd_tok    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (wr && 3'(i) < wr_count) mem_r[wp_r + AW'(i)] <= wr_tok[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(n_in);
      rp_r  <= rp_r + AW'(rd);
      cnt_r <= cnt_r + (AW+1)'(n_in) - (AW+1)'(rd);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(FIFO_DEPTH))
    else $error("token queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd |-> cnt_r != '0)
    else $error("token queue read while empty");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r - rp_r == cnt_r[AW-1:0])
    else $error("token queue pointers disagree with count");

endmodule
